// ===== design/ds_twr_time_of_flight_defines.svh =====
// Assertion macros shared by the ranging pipeline modules
`ifndef DS_TWR_TIME_OF_FLIGHT_DEFINES_SVH
`define DS_TWR_TIME_OF_FLIGHT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset
`define DSTWR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ranging pipeline check failed");

// Next-cycle implication
`define DSTWR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ranging pipeline check failed");

`endif

// ===== design/dstwr_pkg.sv =====
// Types and constants of the two-way ranging time-of-flight block
`timescale 1ns / 1ps
package dstwr_pkg;

	localparam int unsigned FIELD_BITS = 32;
	localparam int unsigned CFG_BITS   = 16;
	localparam logic [CFG_BITS-1:0] CM_PER_TICK_RESET = 16'd30748;
	localparam logic [0:0] REG_CM_PER_TICK = 1'b0;

	typedef struct packed {
		logic [FIELD_BITS-1:0] poll_sent_at_a;
		logic [FIELD_BITS-1:0] reply_got_at_a;
		logic [FIELD_BITS-1:0] final_sent_at_a;
		logic [FIELD_BITS-1:0] poll_got_at_b;
		logic [FIELD_BITS-1:0] reply_sent_at_b;
		logic [FIELD_BITS-1:0] final_got_at_b;
	} stamps_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] flight_ticks;
		logic [15:0]           range_cm;
		logic                  sum_was_zero;
		logic                  range_clipped;
	} flight_t;

endpackage

// ===== design/dstwr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`include "ds_twr_time_of_flight_defines.svh"
module dstwr_div_pipe #(
	parameter int unsigned W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [W+1:0]   in_rem,
	input  logic [W-1:0]   in_low,
	input  logic [W+1:0]   in_den,
	input  logic           in_zero,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [W-1:0]   out_quo,
	output logic           out_zero
);

	logic [W-1:0] v_s;
	logic [W+1:0] rem_s [W];
	logic [W-1:0] low_s [W];
	logic [W+1:0] den_s [W];
	logic [W-1:0] zero_s;
	logic [W:0]   en;

	assign en[W] = !out_stall;

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W+1:0] rem_in;
		logic [W-1:0] low_in;
		logic [W+1:0] den_in;
		logic         zero_in;
		logic         v_in;
		logic [W+2:0] trial;
		logic [W+2:0] diff;

		if (k == 0) begin : g_first
			assign rem_in  = in_rem;
			assign low_in  = in_low;
			assign den_in  = in_den;
			assign zero_in = in_zero;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign low_in  = low_s[k-1];
			assign den_in  = den_s[k-1];
			assign zero_in = zero_s[k-1];
			assign v_in    = v_s[k-1];
		end

		// move up when empty or when the next stage moves
		assign en[k] = !v_s[k] || en[k+1];

		// shift in one dividend bit and try the subtract
		assign trial = {rem_in, low_in[W-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_in;
			end
		end

		// quotient bits enter the low word as dividend bits leave it
		always_ff @(posedge clk) begin
			if (en[k]) begin
				if (trial >= {1'b0, den_in}) begin
					rem_s[k] <= diff[W+1:0];
					low_s[k] <= {low_in[W-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial[W+1:0];
					low_s[k] <= {low_in[W-2:0], 1'b0};
				end
				den_s[k]  <= den_in;
				zero_s[k] <= zero_in;
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_s[W-1];
	assign out_quo   = low_s[W-1];
	assign out_zero  = zero_s[W-1];

	`DSTWR_ASSERT_NEXT(a_div_hold, out_valid && out_stall, out_valid)
	`DSTWR_ASSERT_NOW(a_div_rem, v_s[0] && !zero_s[0], rem_s[0] < den_s[0])
	`DSTWR_ASSERT_NEXT(a_div_take, in_valid && !in_stall, v_s[0])

endmodule

// ===== design/ds_twr_time_of_flight.sv =====
// Top level of the double-sided two-way ranging time-of-flight pipeline
`timescale 1ns / 1ps
// Takes the six timestamps of one ranging exchange per transfer and returns
// the one-way flight time in ticks and the distance in centimeters. One
// transfer can enter every clock unless req_stall holds it. The pipe has three
// front stages for intervals, products and difference, one divider stage per
// quotient bit, then scaling and the output register. The divider is the
// long part of the pipe; stages hold on a stall and empty stages fill up, so
// transfers keep entering while a finished result waits. A zero interval sum
// gives flight 0, distance 0 and sets sum_was_zero. The scale register
// cm_per_tick_q16 sits at APB address 0 and resets to 30748.
`include "ds_twr_time_of_flight_defines.svh"
module ds_twr_time_of_flight
	import dstwr_pkg::*;
#(
	parameter int unsigned STAMP_BITS      = 32,
	parameter int unsigned SCALE_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  stamps_t     req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output flight_t     rsp
);

	localparam int unsigned S  = STAMP_BITS;
	localparam int unsigned XW = (S > FIELD_BITS) ? S : FIELD_BITS;
	localparam int unsigned PW = S + 2 * CFG_BITS + 1;

	logic [CFG_BITS-1:0] cm_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q <= CM_PER_TICK_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CM_PER_TICK) begin
			cm_q <= pwdata[CFG_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CM_PER_TICK) ? {{(32-CFG_BITS){1'b0}}, cm_q} : 32'd0;

	logic en1, en2, en3, en4, en5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic div_stall, div_valid, div_zero;
	logic [S-1:0] div_quo;

	// stage 1: intervals and their sum
	logic [XW-1:0] pta, rga, fsa, pgb, rsb, fgb;
	logic [S-1:0]  trp1, trp2, trd1, trd2;
	logic [S-1:0]  trp1_s1, trp2_s1, trd1_s1, trd2_s1;
	logic [S+1:0]  sum_s1;

	assign pta = XW'(req.poll_sent_at_a);
	assign rga = XW'(req.reply_got_at_a);
	assign fsa = XW'(req.final_sent_at_a);
	assign pgb = XW'(req.poll_got_at_b);
	assign rsb = XW'(req.reply_sent_at_b);
	assign fgb = XW'(req.final_got_at_b);

	// wrap each interval at the stamp width before summing
	assign trp1 = rsb[S-1:0] - pgb[S-1:0];
	assign trp2 = fsa[S-1:0] - rga[S-1:0];
	assign trd1 = rga[S-1:0] - pta[S-1:0];
	assign trd2 = fgb[S-1:0] - rsb[S-1:0];

	assign en1 = !v_s1 || en2;
	assign req_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			trp1_s1 <= trp1;
			trp2_s1 <= trp2;
			trd1_s1 <= trd1;
			trd2_s1 <= trd2;
			sum_s1  <= (S+2)'(trp1) + (S+2)'(trp2) + (S+2)'(trd1) + (S+2)'(trd2);
		end
	end

	// stage 2: the two products
	logic [2*S-1:0] pr_s2, pt_s2;
	logic [S+1:0]   sum_s2;

	assign en2 = !v_s2 || en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pr_s2  <= (2*S)'(trp1_s1) * (2*S)'(trp2_s1);
			pt_s2  <= (2*S)'(trd1_s1) * (2*S)'(trd2_s1);
			sum_s2 <= sum_s1;
		end
	end

	// stage 3: magnitude of the difference, zero-sum flag
	logic [2*S-1:0] diff_s3;
	logic [S+1:0]   den_s3;
	logic           zero_s3;

	assign en3 = !v_s3 || !div_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	// a zero sum divides a zero by one so the divider stays well behaved
	always_ff @(posedge clk) begin
		if (en3) begin
			zero_s3 <= (sum_s2 == '0);
			if (sum_s2 == '0) begin
				diff_s3 <= '0;
				den_s3  <= (S+2)'(1);
			end else begin
				diff_s3 <= (pr_s2 >= pt_s2) ? pr_s2 - pt_s2 : pt_s2 - pr_s2;
				den_s3  <= sum_s2;
			end
		end
	end

	dstwr_div_pipe #(
		.W(S)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_stall  (div_stall),
		.in_rem    ({2'b00, diff_s3[2*S-1:S]}),
		.in_low    (diff_s3[S-1:0]),
		.in_den    (den_s3),
		.in_zero   (zero_s3),
		.out_valid (div_valid),
		.out_stall (!en4),
		.out_quo   (div_quo),
		.out_zero  (div_zero)
	);

	// stage 4: scale ticks to distance
	logic [S-1:0]          ticks_s4;
	logic [S+CFG_BITS-1:0] prod_s4;
	logic                  zero_s4;

	assign en4 = !v_s4 || en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			ticks_s4 <= div_quo;
			prod_s4  <= (S+CFG_BITS)'(div_quo) * (S+CFG_BITS)'(cm_q);
			zero_s4  <= div_zero;
		end
	end

	// stage 5: saturate and hold the result for the receiver
	logic [PW-1:0] cm_full;
	logic [XW:0]   ticks_x;
	logic          clip;
	flight_t       rsp_s5;

	assign cm_full = PW'(prod_s4) >> SCALE_FRAC_BITS;
	assign ticks_x = (XW+1)'(ticks_s4);
	assign clip    = |cm_full[PW-1:16];

	assign en5 = !v_s5 || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			rsp_s5.sum_was_zero  <= zero_s4;
			rsp_s5.range_clipped <= !zero_s4 && clip;
			if (zero_s4) begin
				rsp_s5.flight_ticks <= '0;
				rsp_s5.range_cm     <= '0;
			end else begin
				rsp_s5.flight_ticks <= (|ticks_x[XW:FIELD_BITS]) ? '1
					: ticks_x[FIELD_BITS-1:0];
				rsp_s5.range_cm     <= clip ? 16'hFFFF : cm_full[15:0];
			end
		end
	end

	assign rsp_valid = v_s5;
	assign rsp       = rsp_s5;

	`DSTWR_ASSERT_NOW(a_zero_out, rsp_valid && rsp.sum_was_zero,
		rsp.flight_ticks == '0 && rsp.range_cm == '0 && !rsp.range_clipped)
	`DSTWR_ASSERT_NOW(a_clip_sat, rsp_valid && rsp.range_clipped, rsp.range_cm == 16'hFFFF)
	`DSTWR_ASSERT_NEXT(a_s1_hold, v_s1 && !en1, v_s1 && $stable(sum_s1))
	`DSTWR_ASSERT_NEXT(a_s4_hold, v_s4 && !en4, v_s4 && $stable(prod_s4))

endmodule
